@@ hw/rtl/tlbf_pkg.sv @@
// Shared constants and types for the FIFO-replacement translation buffer.
`timescale 1ns / 1ps
`default_nettype none

package tlbf_pkg;

  localparam int BUFFER_ENTRIES = 16;
  localparam int PID_BITS       = 16;
  localparam int PAGE_BITS      = 12;
  localparam int FRAME_BITS     = 12;

  localparam int IN_DATA_BITS   = ((PID_BITS + PAGE_BITS + FRAME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = ((FRAME_BITS + 7) / 8) * 8;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_UPDATE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                  valid;
    logic [PID_BITS-1:0]   pid;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic rewrite;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tlb_fifo_replacement.sv @@
// Top level: fully associative translation buffer built as a shifting chain of entries.
// Result: registered, valid in the cycle after the input transaction is accepted.
// Throughput: one item per cycle unless out_tready stalls; all entries compare the tag in parallel.
// Insert shifts the whole chain by one entry in the accept cycle (oldest at position 0 drops).
// Reset (rst_n low, synchronous): all entries invalid, buffer disabled, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module tlb_fifo_replacement (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [15:0] process_id, [27:16] page_number, [39:28] frame_number
  input  wire logic [tlbf_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // [0] opcode
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [11:0] found_frame, upper bits zero
  output logic [tlbf_pkg::OUT_DATA_BITS-1:0]       out_tdata,
  // [0] hit
  output logic                                     out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_data
);

  localparam int N = tlbf_pkg::BUFFER_ENTRIES;

  logic                                enable_r;
  logic                                out_valid_r;
  logic                                hit_r;
  logic [tlbf_pkg::FRAME_BITS-1:0]     found_r;

  logic                                in_fire;
  tlbf_pkg::opcode_t                   op;
  logic [tlbf_pkg::PID_BITS-1:0]       pid;
  logic [tlbf_pkg::PAGE_BITS-1:0]      page;
  logic [tlbf_pkg::FRAME_BITS-1:0]     frame;
  tlbf_pkg::entry_t                    new_entry;
  tlbf_pkg::entry_t                    link [N];
  logic [N-1:0]                        match;
  logic                                any_hit;
  logic [tlbf_pkg::FRAME_BITS-1:0]     match_frame;
  tlbf_pkg::cell_ctrl_t                ctrl;

  assign pid   = in_tdata[tlbf_pkg::PID_BITS-1:0];
  assign page  = in_tdata[tlbf_pkg::PID_BITS +: tlbf_pkg::PAGE_BITS];
  assign frame = in_tdata[tlbf_pkg::PID_BITS + tlbf_pkg::PAGE_BITS +: tlbf_pkg::FRAME_BITS];
  assign op    = tlbf_pkg::opcode_t'(in_tuser);

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.pid   = pid;
    new_entry.page  = page;
    new_entry.frame = frame;
  end

  always_comb begin
    match_frame = '0;
    for (int i = 0; i < N; i++) begin
      match_frame = match_frame | (link[i].frame & {tlbf_pkg::FRAME_BITS{match[i]}});
    end
  end

  assign any_hit = enable_r && (|match);

  always_comb begin
    ctrl.shift   = in_fire && enable_r && (op == tlbf_pkg::OP_UPDATE) && !(|match);
    ctrl.rewrite = in_fire && enable_r && (op == tlbf_pkg::OP_UPDATE);
  end

  for (genvar g = 0; g < N; g++) begin : g_chain
    tlbf_pkg::entry_t nb;
    if (g == N - 1) begin : g_tail
      assign nb = new_entry;
    end else begin : g_body
      assign nb = link[g+1];
    end
    tlbf_cell u_entry (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .tag_pid   (pid),
      .tag_page  (page),
      .new_frame (frame),
      .nb_entry  (nb),
      .entry     (link[g]),
      .match     (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hit_r   <= any_hit;
      found_r <= (any_hit && (op == tlbf_pkg::OP_LOOKUP)) ? match_frame : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = hit_r;
  assign out_tdata  = {{(tlbf_pkg::OUT_DATA_BITS - tlbf_pkg::FRAME_BITS){1'b0}}, found_r};

`ifndef SYNTHESIS
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("more than one entry matches the tag");

  a_disabled_miss: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !enable_r |=> !out_tuser)
    else $error("hit reported while buffer disabled");

  a_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (op == tlbf_pkg::OP_UPDATE) |=> (found_r == '0))
    else $error("update result carries a nonzero frame");

  a_insert_tail: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |=> (link[N-1].valid && (link[N-1].pid == $past(pid))
                    && (link[N-1].page == $past(page))))
    else $error("inserted entry missing at chain tail");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tlbf_cell.sv @@
// One translation entry: tag compare, in-place frame rewrite, shift from the neighbor.
`timescale 1ns / 1ps
`default_nettype none

module tlbf_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tlbf_pkg::cell_ctrl_t             ctrl,
  input  wire logic [tlbf_pkg::PID_BITS-1:0]    tag_pid,
  input  wire logic [tlbf_pkg::PAGE_BITS-1:0]   tag_page,
  input  wire logic [tlbf_pkg::FRAME_BITS-1:0]  new_frame,
  input  wire tlbf_pkg::entry_t                 nb_entry,
  output tlbf_pkg::entry_t                      entry,
  output logic                                  match
);

  logic                              valid_r;
  logic [tlbf_pkg::PID_BITS-1:0]     pid_r;
  logic [tlbf_pkg::PAGE_BITS-1:0]    page_r;
  logic [tlbf_pkg::FRAME_BITS-1:0]   frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= nb_entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pid_r   <= nb_entry.pid;
      page_r  <= nb_entry.page;
      frame_r <= nb_entry.frame;
    end else if (ctrl.rewrite && match) begin
      frame_r <= new_frame;
    end
  end

  assign match = valid_r && (pid_r == tag_pid) && (page_r == tag_page);

  always_comb begin
    entry.valid = valid_r;
    entry.pid   = pid_r;
    entry.page  = page_r;
    entry.frame = frame_r;
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the FIFO-replacement translation buffer: directed table plus random traffic.
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 5000;
  localparam int N_ROWS      = 21;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    logic                            hit;
    logic [tlbf_pkg::FRAME_BITS-1:0] frame;
  } translation_t;

  typedef struct {
    row_kind_t                       kind;
    logic                            en;
    tlbf_pkg::opcode_t               op;
    logic [tlbf_pkg::PID_BITS-1:0]   pid;
    logic [tlbf_pkg::PAGE_BITS-1:0]  page;
    logic [tlbf_pkg::FRAME_BITS-1:0] frame;
    logic                            known;
    logic                            hit;
    logic [tlbf_pkg::FRAME_BITS-1:0] found;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [tlbf_pkg::IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                               in_tuser = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [tlbf_pkg::OUT_DATA_BITS-1:0] out_tdata;
  logic                               out_tuser;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic                               cfg_data = 1'b0;

  tlbf_pkg::entry_t tlb_model [tlbf_pkg::BUFFER_ENTRIES];
  logic             model_enable = 1'b0;
  translation_t     pending_q [$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               n_items = 0, n_results = 0, n_cfg = 0;
  int               n_hits = 0, n_rewrites = 0, n_inserts = 0, n_disabled = 0;

  logic [tlbf_pkg::PID_BITS-1:0]  pid_pool [4];
  logic [tlbf_pkg::PAGE_BITS-1:0] page_pool [5];

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'h0000, 12'h000, 12'h000, 1'b1, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_UPDATE, 16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b0, 12'h000},
    '{ROW_CFG,  1'b1, tlbf_pkg::OP_LOOKUP, 16'h0000, 12'h000, 12'h000, 1'b0, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'hFFFF, 12'hFFF, 12'h000, 1'b1, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_UPDATE, 16'h0000, 12'h000, 12'h000, 1'b1, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_UPDATE, 16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'h0000, 12'h000, 12'h000, 1'b1, 1'b1, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'hFFFF, 12'hFFF, 12'h000, 1'b1, 1'b1, 12'hFFF},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_UPDATE, 16'hFFFF, 12'hFFF, 12'hA5A, 1'b1, 1'b1, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'hFFFF, 12'hFFF, 12'h000, 1'b1, 1'b1, 12'hA5A},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'hFFFF, 12'h000, 12'h000, 1'b1, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'h0000, 12'hFFF, 12'h000, 1'b1, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_UPDATE, 16'h1234, 12'h5A5, 12'h3C3, 1'b0, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'h1234, 12'h5A5, 12'h000, 1'b0, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_UPDATE, 16'h8001, 12'h801, 12'h800, 1'b0, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'h8001, 12'h801, 12'h000, 1'b0, 1'b0, 12'h000},
    '{ROW_CFG,  1'b0, tlbf_pkg::OP_LOOKUP, 16'h0000, 12'h000, 12'h000, 1'b0, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'hFFFF, 12'hFFF, 12'h000, 1'b1, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_UPDATE, 16'hFFFF, 12'hFFF, 12'h001, 1'b1, 1'b0, 12'h000},
    '{ROW_CFG,  1'b1, tlbf_pkg::OP_LOOKUP, 16'h0000, 12'h000, 12'h000, 1'b0, 1'b0, 12'h000},
    '{ROW_ITEM, 1'b0, tlbf_pkg::OP_LOOKUP, 16'hFFFF, 12'hFFF, 12'h000, 1'b1, 1'b1, 12'hA5A}
  };

  tlb_fifo_replacement u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic translation_t translate(input tlbf_pkg::opcode_t op,
                                             input logic [tlbf_pkg::PID_BITS-1:0] pid,
                                             input logic [tlbf_pkg::PAGE_BITS-1:0] page,
                                             input logic [tlbf_pkg::FRAME_BITS-1:0] frame);
    translation_t r;
    int slot;
    r.hit = 1'b0;
    r.frame = '0;
    slot = -1;
    if (!model_enable) begin
      n_disabled++;
      return r;
    end
    for (int i = 0; i < tlbf_pkg::BUFFER_ENTRIES; i++)
      if (slot < 0 && tlb_model[i].valid && tlb_model[i].pid == pid && tlb_model[i].page == page)
        slot = i;
    if (slot >= 0) begin
      r.hit = 1'b1;
      if (op == tlbf_pkg::OP_LOOKUP) begin
        r.frame = tlb_model[slot].frame;
        n_hits++;
      end else begin
        tlb_model[slot].frame = frame;
        n_rewrites++;
      end
    end else if (op == tlbf_pkg::OP_UPDATE) begin
      for (int i = 0; i + 1 < tlbf_pkg::BUFFER_ENTRIES; i++)
        tlb_model[i] = tlb_model[i + 1];
      tlb_model[tlbf_pkg::BUFFER_ENTRIES-1] = '{1'b1, pid, page, frame};
      n_inserts++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Call at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(input tlbf_pkg::opcode_t op,
                           input logic [tlbf_pkg::PID_BITS-1:0] pid,
                           input logic [tlbf_pkg::PAGE_BITS-1:0] page,
                           input logic [tlbf_pkg::FRAME_BITS-1:0] frame,
                           input logic known, input logic khit,
                           input logic [tlbf_pkg::FRAME_BITS-1:0] kfound);
    translation_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {frame, page, pid};
    do @(posedge clk); while (!in_tready);
    r = translate(op, pid, page, frame);
    if (known) begin
      r.hit = khit;
      r.frame = kfound;
    end
    pending_q.insert(pending_q.size(), r);
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_enable(input logic en);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_enable = en;
    n_cfg++;
  endtask

  task automatic run_random(input int count);
    tlbf_pkg::opcode_t               op;
    logic [tlbf_pkg::PID_BITS-1:0]   pid;
    logic [tlbf_pkg::PAGE_BITS-1:0]  page;
    logic [tlbf_pkg::FRAME_BITS-1:0] frame;
    logic [31:0]                     rnd;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) == 0)
        drain();
      op = ($urandom_range(99) < 35) ? tlbf_pkg::OP_UPDATE : tlbf_pkg::OP_LOOKUP;
      if ($urandom_range(99) < 85) begin
        pid  = pid_pool[$urandom_range(3)];
        page = page_pool[$urandom_range(4)];
      end else begin
        rnd  = $urandom;
        pid  = rnd[tlbf_pkg::PID_BITS-1:0];
        rnd  = $urandom;
        page = rnd[tlbf_pkg::PAGE_BITS-1:0];
      end
      rnd   = $urandom;
      frame = rnd[tlbf_pkg::FRAME_BITS-1:0];
      send_item(op, pid, page, frame, 1'b0, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    translation_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, hit", 32'(out_tuser), 0);
      end else begin
        want = pending_q.pop_front();
        if (out_tuser !== want.hit)
          report_mismatch("hit", 32'(out_tuser), 32'(want.hit));
        if (out_tdata[tlbf_pkg::FRAME_BITS-1:0] !== want.frame)
          report_mismatch("found_frame", 32'(out_tdata[tlbf_pkg::FRAME_BITS-1:0]),
                          32'(want.frame));
        if (out_tdata[tlbf_pkg::OUT_DATA_BITS-1:tlbf_pkg::FRAME_BITS] !== '0)
          report_mismatch("tdata padding",
                          32'(out_tdata[tlbf_pkg::OUT_DATA_BITS-1:tlbf_pkg::FRAME_BITS]), 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int send_pct [3];
    int recv_pct [3];
    logic [31:0] rnd;
    send_pct = '{7, 73, 0};
    recv_pct = '{73, 7, 0};
    foreach (tlb_model[i]) tlb_model[i] = '0;
    pid_pool[0] = 16'h0000;
    pid_pool[1] = 16'hFFFF;
    rnd = $urandom;
    pid_pool[2] = rnd[tlbf_pkg::PID_BITS-1:0];
    rnd = $urandom;
    pid_pool[3] = rnd[tlbf_pkg::PID_BITS-1:0];
    page_pool[0] = 12'h000;
    page_pool[1] = 12'hFFF;
    rnd = $urandom;
    page_pool[2] = rnd[tlbf_pkg::PAGE_BITS-1:0];
    rnd = $urandom;
    page_pool[3] = rnd[tlbf_pkg::PAGE_BITS-1:0];
    rnd = $urandom;
    page_pool[4] = rnd[tlbf_pkg::PAGE_BITS-1:0];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_enable(directed_rows[i].en);
      else
        send_item(directed_rows[i].op, directed_rows[i].pid, directed_rows[i].page,
                  directed_rows[i].frame, directed_rows[i].known, directed_rows[i].hit,
                  directed_rows[i].found);
    end

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_pct[m];
      recv_idle_pct = recv_pct[m];
      write_enable(1'b1);
      run_random(400);
      write_enable(1'b0);
      run_random(30);
      write_enable(1'b1);
      run_random(20);
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d items, %0d results, %0d enable writes", n_items, n_results, n_cfg);
    $display("Lookup hits %0d, in-place rewrites %0d, inserts %0d, items while disabled %0d",
             n_hits, n_rewrites, n_inserts, n_disabled);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
